// ===== rtl/ggc_pkg.sv =====
// ----------------------------------------------------------------------------
// ggc_pkg: shared types and constants of the Gray real gene codec
// Field widths, register indexes, word kinds and the configuration bundle
// that the register block hands to the pipeline.
// ----------------------------------------------------------------------------
package ggc_pkg;

  localparam int REAL_W     = 32;  // Q16.16 real fields
  localparam int CODE_IO_W  = 16;  // code word fields on the ports
  localparam int GAP_W      = 33;  // high_bound - low_bound
  localparam int ACC_W      = 35;  // leftover or running sum, with headroom
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE  = 2'd2;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  localparam logic signed [REAL_W-1:0] LOW_BOUND_RST  = 32'sd0;
  localparam logic signed [REAL_W-1:0] HIGH_BOUND_RST = 32'sd65536;
  localparam logic                     GRAY_MODE_RST  = 1'b1;

  localparam logic signed [REAL_W-1:0] REAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [REAL_W-1:0] REAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [REAL_W-1:0] low_bound;
    logic signed [GAP_W-1:0]  gap;
    logic                     gray_mode;
  } cfg_t;

endpackage

// ===== rtl/ggc_if.sv =====
// ----------------------------------------------------------------------------
// ggc_if: word channels of the Gray real gene codec
// Valid/ready channels for the request words and the result words.
// ----------------------------------------------------------------------------
interface ggc_in_if;
  import ggc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic signed [REAL_W-1:0]    real_in;
  logic        [CODE_IO_W-1:0] code_in;

  modport source (output valid, kind, real_in, code_in, input ready);
  modport sink   (input valid, kind, real_in, code_in, output ready);
endinterface

interface ggc_out_if;
  import ggc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic        [CODE_IO_W-1:0] code_out;
  logic signed [REAL_W-1:0]    real_out;
  logic                        was_decode;

  modport source (output valid, code_out, real_out, was_decode, input ready);
  modport sink   (input valid, code_out, real_out, was_decode, output ready);
endinterface

// ===== rtl/ggc_cfg.sv =====
// ----------------------------------------------------------------------------
// ggc_cfg: configuration registers
// Holds the interval bounds and the Gray mode flag and keeps the interval
// width registered for the bit stages.
// ----------------------------------------------------------------------------
module ggc_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ggc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ggc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output ggc_pkg::cfg_t                    cfg_o
);
  import ggc_pkg::*;

  logic signed [REAL_W-1:0] low_q, low_d;
  logic signed [REAL_W-1:0] high_q, high_d;
  logic                     gray_q, gray_d;
  logic signed [GAP_W-1:0]  gap_q, gap_d;

  always_comb begin
    low_d  = low_q;
    high_d = high_q;
    gray_d = gray_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOW_BOUND:  low_d  = $signed(cfg_data_i[REAL_W-1:0]);
        REG_HIGH_BOUND: high_d = $signed(cfg_data_i[REAL_W-1:0]);
        REG_GRAY_MODE:  gray_d = cfg_data_i[0];
        default:        ;
      endcase
    end
    // The width is formed one bit wider than the bounds so it never wraps.
    gap_d = GAP_W'(high_q) - GAP_W'(low_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_BOUND_RST;
      high_q <= HIGH_BOUND_RST;
      gray_q <= GRAY_MODE_RST;
      gap_q  <= GAP_W'(HIGH_BOUND_RST) - GAP_W'(LOW_BOUND_RST);
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
      gray_q <= gray_d;
      gap_q  <= gap_d;
    end
  end

  assign cfg_o.low_bound = low_q;
  assign cfg_o.gap       = gap_q;
  assign cfg_o.gray_mode = gray_q;

endmodule

// ===== rtl/ggc_entry.sv =====
// ----------------------------------------------------------------------------
// ggc_entry: pipeline entry stage
// Forms the leftover for encode, or the Gray-undone binary word and the
// starting sum for decode.
// ----------------------------------------------------------------------------
module ggc_entry #(
  parameter int CODE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                kind_i,
  input  logic signed [ggc_pkg::REAL_W-1:0]   real_i,
  input  logic [ggc_pkg::CODE_IO_W-1:0]       code_i,
  input  ggc_pkg::cfg_t                       cfg_i,
  output logic                                valid_o,
  output logic                                kind_o,
  output logic signed [ggc_pkg::ACC_W-1:0]    acc_o,
  output logic [CODE_BITS-1:0]                word_o
);
  import ggc_pkg::*;

  localparam int WIDE_W = 32;

  logic                     valid_q;
  logic                     kind_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [CODE_BITS-1:0]     word_q, word_d;
  logic [WIDE_W-1:0]        code_wide;
  logic [CODE_BITS-1:0]     bin;

  always_comb begin
    // Only the low CODE_BITS of the field belong to the word.
    code_wide = WIDE_W'(code_i);
    bin       = code_wide[CODE_BITS-1:0];
    if (cfg_i.gray_mode) begin
      for (int s = 1; s < CODE_BITS; s = s * 2) begin
        bin = bin ^ (bin >> s);
      end
    end
    if (kind_i == KIND_DECODE) begin
      acc_d  = ACC_W'(cfg_i.low_bound);
      word_d = bin;
    end else begin
      acc_d  = ACC_W'(real_i) - ACC_W'(cfg_i.low_bound);
      word_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q <= kind_i;
      acc_q  <= acc_d;
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign acc_o   = acc_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/ggc_stage.sv =====
// ----------------------------------------------------------------------------
// ggc_stage: one bit stage
// Encode compares the leftover with this bit's weight and subtracts it when
// the bit is set; decode adds the weight when the word bit is set.
// ----------------------------------------------------------------------------
module ggc_stage #(
  parameter int CODE_BITS = 16,
  parameter int POS       = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                kind_i,
  input  logic signed [ggc_pkg::ACC_W-1:0]    acc_i,
  input  logic [CODE_BITS-1:0]                word_i,
  input  logic signed [ggc_pkg::GAP_W-1:0]    gap_i,
  output logic                                valid_o,
  output logic                                kind_o,
  output logic signed [ggc_pkg::ACC_W-1:0]    acc_o,
  output logic [CODE_BITS-1:0]                word_o
);
  import ggc_pkg::*;

  localparam int BIT = CODE_BITS - POS;

  logic                     valid_q;
  logic                     kind_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [CODE_BITS-1:0]     word_q, word_d;
  logic signed [GAP_W-1:0]  weight;
  logic signed [ACC_W-1:0]  weight_x;

  always_comb begin
    // Arithmetic shift gives the floored weight for a negative width too.
    weight   = gap_i >>> POS;
    weight_x = ACC_W'(weight);
    acc_d    = acc_i;
    word_d   = word_i;
    if (kind_i == KIND_DECODE) begin
      if (word_i[BIT]) begin
        acc_d = acc_i + weight_x;
      end
    end else if (acc_i >= weight_x) begin
      word_d[BIT] = 1'b1;
      acc_d       = acc_i - weight_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q <= kind_i;
      acc_q  <= acc_d;
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign acc_o   = acc_q;
  assign word_o  = word_q;

endmodule

// ===== rtl/ggc_exit.sv =====
// ----------------------------------------------------------------------------
// ggc_exit: output stage
// Applies Gray coding to encoded words in Gray mode and saturates decoded sums; the
// register here is the result word the output channel presents.
// ----------------------------------------------------------------------------
module ggc_exit #(
  parameter int CODE_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                kind_i,
  input  logic signed [ggc_pkg::ACC_W-1:0]    acc_i,
  input  logic [CODE_BITS-1:0]                word_i,
  input  logic                                gray_mode_i,
  output logic                                valid_o,
  output logic [ggc_pkg::CODE_IO_W-1:0]       code_o,
  output logic signed [ggc_pkg::REAL_W-1:0]   real_o,
  output logic                                was_decode_o
);
  import ggc_pkg::*;

  localparam int WIDE_W = 32;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(REAL_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(REAL_MIN);

  logic                        valid_q;
  logic [CODE_IO_W-1:0]        code_q, code_d;
  logic signed [REAL_W-1:0]    real_q, real_d;
  logic                        dec_q;
  logic [CODE_BITS-1:0]        coded;
  logic [WIDE_W-1:0]           coded_wide;

  always_comb begin
    coded      = gray_mode_i ? (word_i ^ (word_i >> 1)) : word_i;
    coded_wide = WIDE_W'(coded);
    code_d     = '0;
    real_d     = '0;
    if (kind_i == KIND_DECODE) begin
      if (acc_i > SAT_HI) begin
        real_d = REAL_MAX;
      end else if (acc_i < SAT_LO) begin
        real_d = REAL_MIN;
      end else begin
        real_d = acc_i[REAL_W-1:0];
      end
    end else begin
      code_d = coded_wide[CODE_IO_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_q <= code_d;
      real_q <= real_d;
      dec_q  <= kind_i;
    end
  end

  assign valid_o      = valid_q;
  assign code_o       = code_q;
  assign real_o       = real_q;
  assign was_decode_o = dec_q;

endmodule

// ===== rtl/gray_real_gene_codec_unit.sv =====
// ----------------------------------------------------------------------------
// gray_real_gene_codec_unit: Gray coded real gene quantizer
// Encodes Q16.16 reals into code words over [low_bound, high_bound) and
// decodes code words back, with optional Gray coding, in a bit pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Carries
//  --------  ---  -------------  ------------------------------------------
//  in_i      in   valid / ready  kind, real_in, code_in
//  out_o     out  valid / ready  code_out, real_out, was_decode
//  cfg_*     in   cfg_we_i only  low_bound, high_bound, gray_mode by index
//
// A word is written into the entry stage at the edge that accepts it,
// passes one compare/subtract (or add) stage per code bit, and is
// presented as a valid result once it lands in the output
// stage. The pipeline holds up to CODE_BITS + 2 words, and one word enters
// each cycle when the output side keeps up.
// Each stage loads whenever it is empty or the stage after it loads, so a
// stall on the output fills the bubbles first and then holds every word in
// place; nothing is dropped or repeated. Reset clears the valid bits and
// restores the register defaults; the pipeline data carries no reset.
//
module gray_real_gene_codec_unit #(
  parameter int CODE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ggc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ggc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  ggc_in_if.sink                          in_i,
  ggc_out_if.source                       out_o
);
  import ggc_pkg::*;

  // Stage 0 is the entry stage, stages 1 to CODE_BITS handle one code bit
  // each, and stage CODE_BITS + 1 is the output register.
  localparam int LAST = CODE_BITS + 1;

  cfg_t cfg;

  logic                     en    [LAST+1];
  logic                     vld   [LAST+1];
  logic                     kind  [CODE_BITS+1];
  logic signed [ACC_W-1:0]  acc   [CODE_BITS+1];
  logic [CODE_BITS-1:0]     word  [CODE_BITS+1];

  ggc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Load enables ripple back from the output: a stage takes new data when
  // it holds nothing or its contents move on in the same cycle.
  always_comb begin
    en[LAST] = !vld[LAST] || out_o.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  ggc_entry #(
    .CODE_BITS (CODE_BITS)
  ) u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (in_i.valid),
    .kind_i  (in_i.kind),
    .real_i  (in_i.real_in),
    .code_i  (in_i.code_in),
    .cfg_i   (cfg),
    .valid_o (vld[0]),
    .kind_o  (kind[0]),
    .acc_o   (acc[0]),
    .word_o  (word[0])
  );

  // The most significant bit, with the heaviest weight, comes first.
  for (genvar p = 1; p <= CODE_BITS; p++) begin : g_bit
    ggc_stage #(
      .CODE_BITS (CODE_BITS),
      .POS       (p)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[p]),
      .valid_i (vld[p-1]),
      .kind_i  (kind[p-1]),
      .acc_i   (acc[p-1]),
      .word_i  (word[p-1]),
      .gap_i   (cfg.gap),
      .valid_o (vld[p]),
      .kind_o  (kind[p]),
      .acc_o   (acc[p]),
      .word_o  (word[p])
    );
  end

  ggc_exit #(
    .CODE_BITS (CODE_BITS)
  ) u_exit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en[LAST]),
    .valid_i      (vld[CODE_BITS]),
    .kind_i       (kind[CODE_BITS]),
    .acc_i        (acc[CODE_BITS]),
    .word_i       (word[CODE_BITS]),
    .gray_mode_i  (cfg.gray_mode),
    .valid_o      (vld[LAST]),
    .code_o       (out_o.code_out),
    .real_o       (out_o.real_out),
    .was_decode_o (out_o.was_decode)
  );

  assign out_o.valid = vld[LAST];

endmodule

// ===== dv/tb_gray_real_gene_codec_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gray_real_gene_codec_unit: self-checking bench of the Gray gene codec
// Streams encode and decode words through the codec under several interval
// and coding settings, predicts every result with a local bit-exact model and
// compares each result word field by field, in order, with random idling on
// both channels and a long receiver hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module tb_gray_real_gene_codec_unit;
  import ggc_pkg::*;

  localparam int CODE_BITS   = 16;
  localparam int PIPE_DEPTH  = CODE_BITS + 2;  // words the pipeline can hold
  localparam int HOLD_CYCLES = 300;            // long receiver hold-off

  // One request word as the sender offers it.
  typedef struct {
    logic                        kind;
    logic signed [REAL_W-1:0]    real_in;
    logic        [CODE_IO_W-1:0] code_in;
  } gene_word_t;

  // One result word, as predicted and as observed.
  typedef struct {
    logic        [CODE_IO_W-1:0] code_out;
    logic signed [REAL_W-1:0]    real_out;
    logic                        was_decode;
  } gene_result_t;

  // Clock and reset. Reset is low from time zero and released once.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  // Every block input has a known value from the first instant.
  logic                        cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx  = REG_LOW_BOUND;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        drv_valid = 1'b0;
  logic                        drv_kind  = KIND_ENCODE;
  logic signed [REAL_W-1:0]    drv_real  = '0;
  logic        [CODE_IO_W-1:0] drv_code  = '0;
  logic                        rcv_ready = 1'b0;

  ggc_in_if  gene_in ();
  ggc_out_if gene_out ();

  assign gene_in.valid   = drv_valid;
  assign gene_in.kind    = drv_kind;
  assign gene_in.real_in = drv_real;
  assign gene_in.code_in = drv_code;
  assign gene_out.ready  = rcv_ready;

  gray_real_gene_codec_unit #(
    .CODE_BITS(CODE_BITS)
  ) i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (gene_in),
    .out_o     (gene_out)
  );

  // Local copy of the configuration registers. Bounds are kept wide so the
  // interval gap can be formed without overflow.
  longint cfg_low  = longint'(LOW_BOUND_RST);
  longint cfg_high = longint'(HIGH_BOUND_RST);
  logic   cfg_gray = GRAY_MODE_RST;

  // Words waiting to be offered, and results predicted but not yet seen.
  gene_word_t   gene_words_q[$];
  gene_result_t gene_results_q[$];

  // Knobs that the sequence in the main initial block sets for each phase.
  int unsigned send_gap_max = 4;   // longest gap between sender bursts
  int unsigned stall_pct    = 20;  // chance per cycle that the receiver starts a stall
  int unsigned hold_req_cnt = 0;   // bumped to ask the receiver for a long hold-off

  // Acceptance of a request word at the last rising edge.
  logic in_fire = 1'b0;

  int unsigned n_errors   = 0;
  int unsigned n_checked  = 0;
  int unsigned n_encodes  = 0;
  int unsigned n_decodes  = 0;
  int unsigned n_settings = 1;

  // Bit-exact conversion of one word under the current configuration. Each bit
  // weight is the gap shifted down by the bit position; the arithmetic shift
  // gives the floor, which is what a negative gap needs.
  function automatic gene_result_t convert_gene(gene_word_t w);
    gene_result_t          r;
    longint                gap;
    longint                rest;
    longint                sum;
    longint                weight;
    logic [CODE_IO_W-1:0]  bits;
    gap  = cfg_high - cfg_low;
    bits = '0;
    r.code_out   = '0;
    r.real_out   = '0;
    r.was_decode = w.kind;
    if (w.kind == KIND_ENCODE) begin
      rest = longint'(w.real_in) - cfg_low;
      for (int i = 0; i < CODE_BITS; i++) begin
        weight = gap >>> (i + 1);
        if (rest >= weight) begin
          bits[CODE_BITS-1-i] = 1'b1;
          rest -= weight;
        end
      end
      if (cfg_gray) begin
        bits = bits ^ (bits >> 1);
      end
      r.code_out = bits;
    end else begin
      bits = w.code_in;
      if (cfg_gray) begin
        // Prefix XOR from the top bit turns a Gray word back into binary.
        bits = bits ^ (bits >> 1);
        bits = bits ^ (bits >> 2);
        bits = bits ^ (bits >> 4);
        bits = bits ^ (bits >> 8);
      end
      sum = cfg_low;
      for (int i = 0; i < CODE_BITS; i++) begin
        if (bits[CODE_BITS-1-i]) begin
          sum += gap >>> (i + 1);
        end
      end
      if (sum > longint'(REAL_MAX)) begin
        sum = longint'(REAL_MAX);
      end else if (sum < longint'(REAL_MIN)) begin
        sum = longint'(REAL_MIN);
      end
      r.real_out = sum[REAL_W-1:0];
    end
    return r;
  endfunction

  // Random request word. Most reals land inside the interval so the greedy
  // bit walk is exercised in depth; the rest are corners or fully random.
  function automatic gene_word_t random_word();
    gene_word_t  w;
    int unsigned pick;
    longint      span;
    longint      point;
    w.kind    = 1'($urandom_range(1, 0));
    w.code_in = CODE_IO_W'($urandom);
    w.real_in = $urandom;
    span      = cfg_high - cfg_low;
    pick      = $urandom_range(9, 0);
    if (pick == 0) begin
      case ($urandom_range(6, 0))
        0: w.real_in = REAL_MIN;
        1: w.real_in = REAL_MAX;
        2: w.real_in = cfg_low[REAL_W-1:0];
        3: w.real_in = cfg_high[REAL_W-1:0];
        4: w.real_in = cfg_high[REAL_W-1:0] - 1;
        5: w.real_in = cfg_low[REAL_W-1:0] - 1;
        default: w.real_in = '0;
      endcase
      case ($urandom_range(3, 0))
        0: w.code_in = '0;
        1: w.code_in = '1;
        2: w.code_in = 16'h8000;
        default: w.code_in = 16'h0001;
      endcase
    end else if (pick <= 6) begin
      point     = cfg_low + ((span * longint'($urandom_range(65535, 0))) >>> 16);
      w.real_in = point[REAL_W-1:0];
    end
    return w;
  endfunction

  function automatic gene_word_t make_word(logic kind, logic [REAL_W-1:0] real_v,
                                           logic [CODE_IO_W-1:0] code_v);
    gene_word_t w;
    w.kind    = kind;
    w.real_in = real_v;
    w.code_in = code_v;
    return w;
  endfunction

  // Sender: bursts of random length separated by random gaps. A word that
  // has been offered stays on the channel until it is taken.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : sender
    gene_word_t w;
    if (!drv_valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left  -= 1;
        drv_valid <= 1'b0;
      end else if (gene_words_q.size() != 0) begin
        w = gene_words_q.pop_front();
        drv_kind  <= w.kind;
        drv_real  <= w.real_in;
        drv_code  <= w.code_in;
        drv_valid <= 1'b1;
        if (burst_left != 0) begin
          burst_left -= 1;
        end else begin
          burst_left = $urandom_range(24, 1);
          gap_left   = (send_gap_max == 0) ? 0 : $urandom_range(send_gap_max, 0);
        end
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Receiver: short stalls of random length started at random, plus a long
  // hold-off whenever the sequence asks for one. The hold-off is counted here.
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin : receiver
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left -= 1;
      rcv_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left -= 1;
      rcv_ready  <= 1'b0;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      stall_left = $urandom_range(6, 0);
      rcv_ready  <= 1'b0;
    end else begin
      rcv_ready <= 1'b1;
    end
  end

  // Monitor: predicts a result for every accepted request word and checks
  // every accepted result word against the oldest prediction.
  always @(posedge clk) begin : monitor
    gene_word_t   w;
    gene_result_t want;
    gene_result_t got;
    in_fire = gene_in.valid && gene_in.ready;
    if (in_fire) begin
      w.kind    = gene_in.kind;
      w.real_in = gene_in.real_in;
      w.code_in = gene_in.code_in;
      gene_results_q.push_back(convert_gene(w));
    end
    if (gene_out.valid && gene_out.ready) begin
      got.code_out   = gene_out.code_out;
      got.real_out   = gene_out.real_out;
      got.was_decode = gene_out.was_decode;
      if (gene_results_q.size() == 0) begin
        n_errors += 1;
        $display("%0t: result word with nothing pending: code %h real %h decode %b",
                 $time, got.code_out, got.real_out, got.was_decode);
      end else begin
        want = gene_results_q.pop_front();
        n_checked += 1;
        if (want.was_decode) n_decodes += 1;
        else n_encodes += 1;
        if (got.code_out !== want.code_out || got.real_out !== want.real_out ||
            got.was_decode !== want.was_decode) begin
          n_errors += 1;
          $display("%0t: mismatch: expected code %h real %h decode %b,",
                   $time, want.code_out, want.real_out, want.was_decode);
          $display("%0t:           got code %h real %h decode %b",
                   $time, got.code_out, got.real_out, got.was_decode);
        end
      end
    end
  end

  // Register write at a falling edge. The local copy follows at once, which is
  // safe because writes only happen while the pipeline is empty.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_LOW_BOUND:  cfg_low  = longint'(signed'(data));
      REG_HIGH_BOUND: cfg_high = longint'(signed'(data));
      REG_GRAY_MODE:  cfg_gray = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_interval(logic [REAL_W-1:0] low, logic [REAL_W-1:0] high, logic gray);
    write_cfg(REG_LOW_BOUND, low);
    write_cfg(REG_HIGH_BOUND, high);
    write_cfg(REG_GRAY_MODE, {{(CFG_DATA_W-1){1'b0}}, gray});
    n_settings += 1;
  endtask

  // Waits until the sender has nothing left and every result has come back.
  task automatic drain();
    while (gene_words_q.size() != 0 || drv_valid || gene_results_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) gene_words_q.push_back(random_word());
  endtask

  localparam int PHASE_ITEMS = 85;

  initial begin : sequence_main
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: the unit interval in Gray mode. The directed words hit
    // reals below, inside, at and above the interval, the full-scale reals,
    // and the all-zero, all-one and alternating code words.
    gene_words_q.push_back(make_word(KIND_ENCODE, 32'h0000_0000, '0));
    gene_words_q.push_back(make_word(KIND_ENCODE, 32'h0000_8000, '0));
    gene_words_q.push_back(make_word(KIND_ENCODE, 32'h0000_FFFF, '0));
    gene_words_q.push_back(make_word(KIND_ENCODE, 32'h0001_0000, '0));
    gene_words_q.push_back(make_word(KIND_ENCODE, 32'hFFFF_FFFF, '0));
    gene_words_q.push_back(make_word(KIND_ENCODE, REAL_MAX, '0));
    gene_words_q.push_back(make_word(KIND_ENCODE, REAL_MIN, '0));
    gene_words_q.push_back(make_word(KIND_DECODE, '0, 16'h0000));
    gene_words_q.push_back(make_word(KIND_DECODE, '0, 16'hFFFF));
    gene_words_q.push_back(make_word(KIND_DECODE, '0, 16'h8000));
    gene_words_q.push_back(make_word(KIND_DECODE, '0, 16'h0001));
    gene_words_q.push_back(make_word(KIND_DECODE, '0, 16'hAAAA));
    gene_words_q.push_back(make_word(KIND_DECODE, '0, 16'h5555));
    queue_random(PHASE_ITEMS);
    drain();

    // Widest interval, plain binary.
    set_interval(REAL_MIN, REAL_MAX, 1'b0);
    queue_random(PHASE_ITEMS);
    drain();

    // High below low: the gap is negative, and in Gray mode the code 8000, all
    // ones in binary, runs the sum down near the bottom of the signed range.
    set_interval(REAL_MAX, REAL_MIN, 1'b1);
    gene_words_q.push_back(make_word(KIND_DECODE, '0, 16'h8000));
    gene_words_q.push_back(make_word(KIND_DECODE, '0, 16'hFFFF));
    gene_words_q.push_back(make_word(KIND_ENCODE, REAL_MIN, '0));
    gene_words_q.push_back(make_word(KIND_ENCODE, REAL_MAX, '0));
    queue_random(PHASE_ITEMS);
    drain();

    // Empty interval: every weight is zero.
    set_interval(32'h0001_2345, 32'h0001_2345, 1'b0);
    queue_random(PHASE_ITEMS);
    drain();

    // Back pressure: the receiver holds off for a long stretch while the
    // sender offers without gaps, so the pipeline fills and stalls its input.
    set_interval(32'hFFFD_0000, 32'h0005_0000, 1'b1);
    send_gap_max = 0;
    stall_pct    = 10;
    hold_req_cnt += 1;
    queue_random(PHASE_ITEMS);
    drain();

    // Random bounds in either order.
    send_gap_max = 6;
    stall_pct    = 30;
    set_interval($urandom, $urandom, 1'($urandom_range(1, 0)));
    queue_random(PHASE_ITEMS);
    drain();

    // Tiny interval, where most weights truncate to zero.
    send_gap_max = 3;
    stall_pct    = 15;
    set_interval(32'h0001_0000, 32'h0001_0007, 1'($urandom_range(1, 0)));
    queue_random(PHASE_ITEMS);
    drain();

    // Random bounds with no idling on either side.
    send_gap_max = 0;
    stall_pct    = 0;
    set_interval($urandom, $urandom, 1'($urandom_range(1, 0)));
    queue_random(PHASE_ITEMS);
    drain();

    // Idle on after the drain so a stray late result is caught.
    repeat (2 * PIPE_DEPTH) @(negedge clk);

    $display("Checked %0d result words (%0d encodes, %0d decodes) over %0d settings.",
             n_checked, n_encodes, n_decodes, n_settings);
    $display("Settings covered the widest, reversed, empty and tiny intervals; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #1_600_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ggc_pkg.sv
rtl/ggc_if.sv
rtl/ggc_cfg.sv
rtl/ggc_entry.sv
rtl/ggc_stage.sv
rtl/ggc_exit.sv
rtl/gray_real_gene_codec_unit.sv
dv/tb_gray_real_gene_codec_unit.sv
